FILE: rtl/core/t32x_pkg.sv
// shared types, decode constants and helper functions for the wide load/store decoder
package t32x_pkg;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_ADD      = 3'd1,
    KIND_SUB      = 3'd2,
    KIND_MULTI_DB = 3'd3,
    KIND_DOUBLE   = 3'd4,
    KIND_REG_OFF  = 3'd5,
    KIND_UNPRIV   = 3'd6
  } kind_t;

  typedef struct packed {
    logic [15:0] first_half;
    logic [15:0] second_half;
    logic [31:0] rn_value;
    logic [31:0] index_value;
    logic [31:0] pc_value;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_load;
    logic [3:0]  target_reg;
    logic [3:0]  second_reg;
    logic [31:0] alu_result;
    logic [31:0] access_address;
    logic [2:0]  access_bytes;
    logic        sign_extend;
    logic        base_update;
    logic [31:0] new_base;
    logic [15:0] register_list;
    logic        align_fault;
  } result_t;

  localparam logic [15:0] MASK_WIDE   = 16'hfbf0;
  localparam logic [15:0] OP_ADDW     = 16'hf200;
  localparam logic [15:0] OP_SUBW     = 16'hf2a0;
  localparam logic [15:0] MASK_MULTI  = 16'hffc0;
  localparam logic [15:0] OP_MULTI_DB = 16'he900;
  localparam logic [15:0] MASK_DOUBLE = 16'hfe40;
  localparam logic [15:0] OP_DOUBLE   = 16'he840;
  localparam logic [15:0] MASK_ROFF   = 16'h0fc0;
  localparam logic [15:0] MASK_UNPRIV = 16'h0f00;
  localparam logic [15:0] OP_UNPRIV   = 16'h0e00;
  localparam logic [15:0] MASK_NARROW = 16'hfff0;
  localparam logic [15:0] OP_STRB     = 16'hf800;
  localparam logic [15:0] OP_LDRB     = 16'hf810;
  localparam logic [15:0] OP_STRH     = 16'hf820;
  localparam logic [15:0] OP_LDRH     = 16'hf830;
  localparam logic [15:0] OP_STR      = 16'hf840;
  localparam logic [15:0] OP_LDR      = 16'hf850;
  localparam logic [15:0] OP_LDRSB    = 16'hf910;
  localparam logic [15:0] OP_LDRSH    = 16'hf930;

  localparam logic [3:0] REG_PC = 4'hf;

  localparam logic [2:0] BYTES_ONE  = 3'd1;
  localparam logic [2:0] BYTES_HALF = 3'd2;
  localparam logic [2:0] BYTES_WORD = 3'd4;

  // adder tree over the list bits
  function automatic logic [4:0] count_regs(input logic [15:0] list);
    logic [1:0] s1 [8];
    logic [2:0] s2 [4];
    logic [3:0] s3 [2];
    for (int i = 0; i < 8; i++) begin
      s1[i] = {1'b0, list[2*i]} + {1'b0, list[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    return {1'b0, s3[0]} + {1'b0, s3[1]};
  endfunction

  // lowest nibble first, then lowest bit within it
  function automatic logic [3:0] lowest_reg(input logic [15:0] list);
    logic [1:0] nib;
    logic [3:0] sel;
    logic [1:0] bit_pos;
    if (list[3:0] != 4'd0) nib = 2'd0;
    else if (list[7:4] != 4'd0) nib = 2'd1;
    else if (list[11:8] != 4'd0) nib = 2'd2;
    else nib = 2'd3;
    sel = list[{nib, 2'b00} +: 4];
    if (sel[0]) bit_pos = 2'd0;
    else if (sel[1]) bit_pos = 2'd1;
    else if (sel[2]) bit_pos = 2'd2;
    else bit_pos = 2'd3;
    return {nib, bit_pos};
  endfunction

endpackage

FILE: rtl/core/t32x_decode.sv
// instruction class decode and address generation for one registered transaction
module t32x_decode
  import t32x_pkg::*;
(
  input  cmd_t    cmd,
  output result_t res
);

  logic [15:0] a;
  logic [15:0] b;
  logic [15:0] op_wide;
  logic [15:0] op_narrow;
  logic [31:0] left;
  logic [31:0] imm;
  logic [4:0]  count;
  logic [31:0] multi_addr;
  logic [31:0] dw_off;
  logic [31:0] dw_oaddr;
  logic [31:0] dw_addr;
  logic [31:0] roff_addr;
  logic [31:0] unpriv_addr;
  logic        narrow_ok;
  logic        regoff;
  logic        load;

  assign a = cmd.first_half;
  assign b = cmd.second_half;
  assign op_wide   = a & MASK_WIDE;
  assign op_narrow = a & MASK_NARROW;

  assign left = (a[3:0] == REG_PC) ? {cmd.pc_value[31:2], 2'b00} : cmd.rn_value;
  assign imm  = {20'd0, a[10], b[14:12], b[7:0]};

  assign count      = count_regs(b);
  assign multi_addr = cmd.rn_value - {25'd0, count, 2'b00};

  assign dw_off   = {22'd0, b[7:0], 2'b00};
  assign dw_oaddr = a[7] ? (cmd.rn_value + dw_off) : (cmd.rn_value - dw_off);
  assign dw_addr  = a[8] ? dw_oaddr : cmd.rn_value;

  assign roff_addr   = cmd.rn_value + (cmd.index_value << b[5:4]);
  assign unpriv_addr = cmd.rn_value + {24'd0, b[7:0]};

  assign narrow_ok = (op_narrow == OP_STRB)  || (op_narrow == OP_LDRB)  ||
                     (op_narrow == OP_STRH)  || (op_narrow == OP_LDRH)  ||
                     (op_narrow == OP_STR)   || (op_narrow == OP_LDR)   ||
                     (op_narrow == OP_LDRSB) || (op_narrow == OP_LDRSH);
  assign regoff = ((b & MASK_ROFF) == 16'd0);
  assign load   = op_narrow[4];

  always_comb begin
    res = '0;
    if ((op_wide == OP_ADDW) || (op_wide == OP_SUBW)) begin
      res.kind       = (op_wide == OP_ADDW) ? KIND_ADD : KIND_SUB;
      res.target_reg = b[11:8];
      res.alu_result = (op_wide == OP_ADDW) ? (left + imm) : (left - imm);
    end else if (((a & MASK_MULTI) == OP_MULTI_DB) && (b != 16'd0)) begin
      res.kind             = KIND_MULTI_DB;
      res.is_load          = a[4];
      res.target_reg       = lowest_reg(b);
      res.access_address   = multi_addr;
      res.access_bytes     = BYTES_WORD;
      res.new_base         = multi_addr;
      res.register_list    = b;
      res.align_fault      = (multi_addr[1:0] != 2'b00);
      res.base_update      = a[5] && (multi_addr[1:0] == 2'b00);
    end else if (((a & MASK_DOUBLE) == OP_DOUBLE) && (a[8] || a[5])) begin
      res.kind             = KIND_DOUBLE;
      res.is_load          = a[4];
      res.target_reg       = b[15:12];
      res.second_reg       = b[11:8];
      res.access_address   = dw_addr;
      res.access_bytes     = BYTES_WORD;
      res.new_base         = dw_oaddr;
      res.align_fault      = (dw_addr[1:0] != 2'b00);
      res.base_update      = a[5] && (dw_addr[1:0] == 2'b00);
    end else if (narrow_ok && (regoff || ((b & MASK_UNPRIV) == OP_UNPRIV))) begin
      res.kind           = regoff ? KIND_REG_OFF : KIND_UNPRIV;
      res.is_load        = load;
      res.target_reg     = b[15:12];
      res.access_address = regoff ? roff_addr : unpriv_addr;
      if (op_narrow[6]) res.access_bytes = BYTES_WORD;
      else if (op_narrow[5]) res.access_bytes = BYTES_HALF;
      else res.access_bytes = BYTES_ONE;
      res.sign_extend    = load && op_narrow[8];
    end
  end

endmodule

FILE: rtl/core/thumb32_extra_decode_agu.sv
// top level: input register, decode and address generation, result register
//
// usage:
//   a transaction is accepted at a rising edge with start high and busy low.
//   busy is held low, so one instruction can be issued every cycle.
//   cmd carries the two instruction halfwords, the base and index register
//   values and the raw program counter.
//   the decoded result appears on result with done high for exactly one
//   cycle; the receiver takes it at the edge that ends that cycle and
//   cannot stall it.
// registers: the command is captured in the input register when accepted;
//   the decoded result and done are then registered in the result register,
//   from which the receiver takes them.
// throughput: one transaction per cycle, set by the single decode stage
//   between the input and result registers.
// reset: rst is synchronous; it drops any transaction in flight and clears
//   done. there is no other control state, so the block is ready at once after.
module thumb32_extra_decode_agu
  import t32x_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  logic    stage_valid;
  cmd_t    stage_cmd;
  result_t decoded;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stage_cmd <= cmd;
    end
  end

  t32x_decode u_decode (
    .cmd (stage_cmd),
    .res (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      result <= decoded;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(stage_valid))
    else $error("result strobe without a transaction in the stage");

  a_fault_blocks_wb: assert property (@(posedge clk) disable iff (rst)
    (done && result.align_fault) |-> !result.base_update)
    else $error("write-back set on an alignment fault");

  a_unhandled_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.kind == KIND_NONE)) |-> (result == '0))
    else $error("unhandled encoding with nonzero fields");

  a_access_size: assert property (@(posedge clk) disable iff (rst)
    (done && (result.access_bytes == 3'd0)) |->
      ((result.kind == KIND_NONE) || (result.kind == KIND_ADD) ||
       (result.kind == KIND_SUB)))
    else $error("memory class without an access size");

endmodule
